/* rtl/window_pair_sum_check_defines.svh */
// Assertion macros shared by the RTL of the window pair sum checker.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef WINDOW_PAIR_SUM_CHECK_DEFINES_SVH
`define WINDOW_PAIR_SUM_CHECK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/wpsc_pkg.sv */
// Package of the window pair sum checker: field widths, reset values and the result type.
// No dependencies; the interfaces, pair unit, sequencer and top refer to it by scoped names.
`default_nettype none

package wpsc_pkg;

	localparam int VALUE_W        = 63;
	localparam int SUM_W          = 64;
	localparam int WLEN_W         = 6;
	localparam int MAX_WINDOW_DEF = 32;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd25;

	typedef struct packed {
		logic               checked;
		logic               hit;
		logic [VALUE_W-1:0] value;
	} res_t;

endpackage

`default_nettype wire

/* rtl/wpsc_ifs.sv */
// Valid/ready channel interfaces for the input stream, the result stream and the config write.
// Depends on wpsc_pkg for the payload widths.
`default_nettype none

interface wpsc_in_if;
	logic                          valid;
	logic                          ready;
	logic [wpsc_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface wpsc_out_if;
	logic                          valid;
	logic                          ready;
	logic                          checked;
	logic                          is_pair_sum;
	logic [wpsc_pkg::VALUE_W-1:0]  echo_value;

	modport source (output valid, output checked, output is_pair_sum, output echo_value,
		input ready);
	modport sink   (input valid, input checked, input is_pair_sum, input echo_value,
		output ready);
endinterface

interface wpsc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [wpsc_pkg::WLEN_W-1:0]   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/wpsc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module wpsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/wpsc_pair_unit.sv */
// Shared adder and comparator: checks whether two history entries sum to the target.
// Depends on wpsc_pkg for the value and sum widths.
`default_nettype none

module wpsc_pair_unit (
	input  wire logic [wpsc_pkg::VALUE_W-1:0] va,
	input  wire logic [wpsc_pkg::VALUE_W-1:0] vb,
	input  wire logic [wpsc_pkg::VALUE_W-1:0] target,
	output logic                              match
);

	logic [wpsc_pkg::SUM_W-1:0] sum;

	// The sum is one bit wider than the operands, so it never wraps.
	assign sum   = {1'b0, va} + {1'b0, vb};
	assign match = (sum == {1'b0, target});

endmodule

`default_nettype wire

/* rtl/wpsc_seq.sv */
// Sequencer of the window pair sum checker: ring bookkeeping, pair scan and history writes.
// Depends on wpsc_pkg, wpsc_ram, wpsc_pair_unit and the assertion macro header.
`default_nettype none
`include "window_pair_sum_check_defines.svh"

module wpsc_seq #(
	parameter int MAX_WINDOW = wpsc_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire logic [wpsc_pkg::VALUE_W-1:0]     in_value,
	output logic                                  in_ready,
	input  wire logic [wpsc_pkg::WLEN_W-1:0]      window_len,
	input  wire logic                             res_ready,
	output logic                                  done,
	output wpsc_pkg::res_t                        res
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (LW > wpsc_pkg::WLEN_W) ? LW : wpsc_pkg::WLEN_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOADA  = 3'd1;
	localparam logic [2:0] S_LATCHA = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_TAIL   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]                    state_q;
	logic [LW-1:0]                 len_q;
	logic [LW-1:0]                 a_q;
	logic [LW-1:0]                 b_q;
	logic                          chk_q;
	logic                          hit_q;
	logic                          cmp_vld_q;
	logic [AW-1:0]                 write_slot_q;
	logic [LW-1:0]                 fill_q;
	logic [wpsc_pkg::VALUE_W-1:0]  target_q;
	logic [wpsc_pkg::VALUE_W-1:0]  va_q;

	logic [CW-1:0]                 wl_ext;
	logic [LW-1:0]                 eff_len;
	logic                          eff_chk;
	logic [LW-1:0]                 age;
	logic [LW:0]                   slot_raw;
	logic [LW:0]                   slot_wrap;
	logic [AW-1:0]                 rd_addr;
	logic                          rd_en;
	logic                          wr_en;
	logic [wpsc_pkg::VALUE_W-1:0]  rd_data;
	logic                          match;
	logic                          hit_now;
	logic                          last_b;
	logic                          more_a;

	// Window length clamped to the range from two to MAX_WINDOW.
	always_comb begin
		wl_ext = CW'(window_len);
		if (wl_ext < CW'(2)) begin
			eff_len = LW'(2);
		end else if (wl_ext > CW'(MAX_WINDOW)) begin
			eff_len = LW'(MAX_WINDOW);
		end else begin
			eff_len = wl_ext[LW-1:0];
		end
	end

	assign eff_chk = (fill_q >= eff_len);

	// Ring slot of the entry pushed age steps before the newest one.
	assign age       = (state_q == S_LOADA) ? a_q : b_q;
	assign slot_raw  = (LW+1)'(write_slot_q) + (LW+1)'(MAX_WINDOW - 1) - (LW+1)'(age);
	assign slot_wrap = (slot_raw >= (LW+1)'(MAX_WINDOW)) ?
		(slot_raw - (LW+1)'(MAX_WINDOW)) : slot_raw;
	assign rd_addr   = slot_wrap[AW-1:0];

	assign rd_en    = (state_q == S_LOADA) || (state_q == S_SCAN);
	assign wr_en    = (state_q == S_DONE) && res_ready;
	assign done     = wr_en;
	assign in_ready = (state_q == S_IDLE);

	assign hit_now = cmp_vld_q && match;
	assign last_b  = (b_q == (len_q - LW'(1)));
	assign more_a  = ((LW+1)'(a_q) + (LW+1)'(2)) < (LW+1)'(len_q);

	wpsc_ram #(
		.WIDTH (wpsc_pkg::VALUE_W),
		.DEPTH (MAX_WINDOW)
	) u_hist (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (write_slot_q),
		.wr_data (target_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wpsc_pair_unit u_pair (
		.va     (va_q),
		.vb     (rd_data),
		.target (target_q),
		.match  (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			a_q          <= '0;
			b_q          <= '0;
			chk_q        <= 1'b0;
			hit_q        <= 1'b0;
			cmp_vld_q    <= 1'b0;
			write_slot_q <= '0;
			fill_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						len_q   <= eff_len;
						chk_q   <= eff_chk;
						hit_q   <= 1'b0;
						a_q     <= '0;
						state_q <= eff_chk ? S_LOADA : S_DONE;
					end
				end
				S_LOADA: begin
					state_q <= S_LATCHA;
				end
				S_LATCHA: begin
					b_q       <= a_q + LW'(1);
					cmp_vld_q <= 1'b0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					if (hit_now) begin
						hit_q     <= 1'b1;
						cmp_vld_q <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						cmp_vld_q <= 1'b1;
						if (last_b) begin
							state_q <= S_TAIL;
						end else begin
							b_q <= b_q + LW'(1);
						end
					end
				end
				S_TAIL: begin
					cmp_vld_q <= 1'b0;
					if (hit_now) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (more_a) begin
						a_q     <= a_q + LW'(1);
						state_q <= S_LOADA;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						if (write_slot_q == AW'(MAX_WINDOW - 1)) begin
							write_slot_q <= '0;
						end else begin
							write_slot_q <= write_slot_q + AW'(1);
						end
						if (fill_q < LW'(MAX_WINDOW)) begin
							fill_q <= fill_q + LW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			target_q <= in_value;
		end
		if (state_q == S_LATCHA) begin
			va_q <= rd_data;
		end
	end

	assign res.checked = chk_q;
	assign res.hit     = hit_q;
	assign res.value   = target_q;

	`WPSC_ASSERT_NOW(a_idle_no_cmp, state_q == S_IDLE, !cmp_vld_q, "Compare pending while idle.")
	`WPSC_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= LW'(MAX_WINDOW), "Fill count above window size.")
	`WPSC_ASSERT_NOW(a_unchecked_miss, done && !chk_q, !hit_q, "Hit reported without a check.")
	`WPSC_ASSERT_NOW(a_check_filled, done && chk_q, fill_q >= len_q, "Check ran on a short ring.")
	`WPSC_ASSERT_NEXT(a_done_idle, done, state_q == S_IDLE, "Sequencer not idle after a result.")

endmodule

`default_nettype wire

/* rtl/window_pair_sum_check.sv */
// Window pair sum checker. A value in the preamble skips the pair scan and goes from IDLE to DONE.
// A checked value with window length L is compared with the sum of every pair of the newest L entries
// until a hit, by one shared adder and comparator that visits one pair per cycle while in the SCAN state.
// The next value is accepted no earlier than the cycle after the result enters the output register.
// Reset clears the ring pointer, fill count and output valid and sets window_len to 25.
`default_nettype none

module window_pair_sum_check #(
	parameter int MAX_WINDOW = wpsc_pkg::MAX_WINDOW_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	wpsc_cfg_if.sink    cfg,
	wpsc_in_if.sink     din,
	wpsc_out_if.source  dout
);

	logic [wpsc_pkg::WLEN_W-1:0] wlen_q;
	logic                        out_vld_q;
	wpsc_pkg::res_t              res_q;
	wpsc_pkg::res_t              res;
	logic                        done;
	logic                        res_ready;

	assign cfg.ready = 1'b1;
	assign res_ready = !out_vld_q || dout.ready;

	wpsc_seq #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (din.valid),
		.in_value   (din.value),
		.in_ready   (din.ready),
		.window_len (wlen_q),
		.res_ready  (res_ready),
		.done       (done),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= wpsc_pkg::WLEN_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				wlen_q <= cfg.data;
			end
			if (done) begin
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign dout.valid       = out_vld_q;
	assign dout.checked     = res_q.checked;
	assign dout.is_pair_sum = res_q.hit;
	assign dout.echo_value  = res_q.value;

endmodule

`default_nettype wire
